// ===== sv/expression_lexer_defines.svh =====
// Assertion macros for the expression lexer.
`ifndef EXPRESSION_LEXER_DEFINES_SVH
`define EXPRESSION_LEXER_DEFINES_SVH
`ifndef ASSERT_OFF
`define EXL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EXL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EXL_ASSERT(label, clk, rst_n, prop, msg)
`define EXL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== sv/exl_pkg.sv =====
// Package for the expression lexer: token codes, modes, keyword tables.
`default_nettype none
package exl_pkg;

    localparam int NAME_BUF_LEN_DEF = 9;
    localparam int POS_WIDTH_DEF    = 16;
    localparam int MAX_TOK          = 3;

    typedef enum logic [3:0] {
        TK_NUMBER  = 4'd0,
        TK_OPER    = 4'd1,
        TK_PAREN   = 4'd2,
        TK_COMMA   = 4'd3,
        TK_FUNC    = 4'd4,
        TK_CONST   = 4'd5,
        TK_IDENT   = 4'd6,
        TK_EQUALS  = 4'd7,
        TK_END     = 4'd8,
        TK_ERROR   = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        ERR_SECOND_POINT   = 2'd0,
        ERR_TRAILING_POINT = 2'd1,
        ERR_UNEXPECTED     = 2'd2,
        ERR_TOO_LONG       = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_NUM     = 2'd1,
        MODE_NAME    = 2'd2,
        MODE_DISCARD = 2'd3
    } mode_t;

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // keyword table: 9 chars, zero padded, plus length
    localparam int KW_CHARS = 9;
    typedef logic [KW_CHARS*8-1:0] kw_text_t;

    localparam int N_FUNC  = 20;
    localparam int N_CONST = 7;

    function automatic kw_text_t func_text(input int i);
        kw_text_t t;
        t = '0;
        unique case (i)
            0:  t[23:0] = "nis";
            1:  t[23:0] = "soc";
            2:  t[23:0] = "nat";
            3:  t[31:0] = "nisa";
            4:  t[47:0] = "niscra";
            5:  t[31:0] = "soca";
            6:  t[47:0] = "soccra";
            7:  t[31:0] = "nata";
            8:  t[47:0] = "natcra";
            9:  t[23:0] = "gol";
            10: t[15:0] = "nl";
            11: t[39:0] = "01gol";
            12: t[31:0] = "2gol";
            13: t[23:0] = "pxe";
            14: t[31:0] = "trqs";
            15: t[31:0] = "trbc";
            16: t[31:0] = "toor";
            17: t[23:0] = "wop";
            18: t[31:0] = "tcaf";
            default: t[71:0] = "lairotcaf";
        endcase
        return t;
    endfunction

    function automatic logic [3:0] func_len(input int i);
        logic [3:0] l;
        unique case (i)
            0, 1, 2, 9, 13, 17: l = 4'd3;
            4, 6, 8:            l = 4'd6;
            10:                 l = 4'd2;
            11:                 l = 4'd5;
            19:                 l = 4'd9;
            default:            l = 4'd4;
        endcase
        return l;
    endfunction

    function automatic kw_text_t const_text(input int i);
        kw_text_t t;
        t = '0;
        unique case (i)
            0: t[15:0] = "ip";
            1: t[7:0]  = "e";
            2: t[7:0]  = "g";
            3: t[15:0] = "aN";
            4: t[7:0]  = "k";
            5: t[7:0]  = "h";
            default: t[7:0] = "q";
        endcase
        return t;
    endfunction

    function automatic logic [3:0] const_len(input int i);
        return (i == 0 || i == 3) ? 4'd2 : 4'd1;
    endfunction

    // token word as it leaves the lexer core
    typedef struct packed {
        kind_t      kind;
        logic [1:0] prec;
        logic [7:0] chr;
        err_t       err;
        logic       run_end;
    } tok_ctl_t;

endpackage
`default_nettype wire

// ===== sv/exl_front.sv =====
// Front end: character classification, lexer state, token generation.
`default_nettype none
module exl_front
    import exl_pkg::*;
#(
    parameter int NAME_BUF_LEN = NAME_BUF_LEN_DEF,
    parameter int POS_WIDTH    = POS_WIDTH_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic [7:0]           ch,
    input  wire logic                 has_char,
    input  wire logic                 last,
    output logic [1:0]                tok_cnt,
    output tok_ctl_t [MAX_TOK-1:0]    tok_ctl,
    output logic [MAX_TOK-1:0][POS_WIDTH-1:0] tok_start,
    output logic [MAX_TOK-1:0][POS_WIDTH-1:0] tok_len,
    output logic [MAX_TOK-1:0][4:0]   tok_kw
);
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam int BW = $clog2(NAME_BUF_LEN);

    mode_t                mode_reg, mode_next;
    logic                 seen_reg, seen_next;
    logic                 ewp_reg, ewp_next;
    logic [POS_WIDTH-1:0] start_reg, start_next;
    logic [POS_WIDTH-1:0] rlen_reg, rlen_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic                 ntl_reg, ntl_next;
    logic [7:0]           name_reg [NAME_BUF_LEN];
    logic                 nw_en;
    logic [BW-1:0]        nw_addr;

    logic [7:0]           lv_name [NAME_BUF_LEN];
    logic [POS_WIDTH-1:0] lv_len;
    logic                 lv_ntl;

    logic is_digit, is_alpha, is_ws;
    logic func_hit, const_hit;
    logic [4:0] func_idx, const_idx;

    always_comb
    begin
        is_digit = (ch >= 8'h30) && (ch <= 8'h39);
        is_alpha = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
        is_ws    = (ch == 8'h20) || (ch == CH_TAB) || (ch == 8'h0A) || (ch == 8'h0D);
    end

    // letter run as it stands after this word's character
    always_comb
    begin
        for (int j = 0; j < NAME_BUF_LEN; j++)
            lv_name[j] = name_reg[j];
        lv_len = rlen_reg;
        lv_ntl = ntl_reg;
        if (has_char && is_alpha && mode_reg == MODE_NAME)
        begin
            if (rlen_reg < POS_WIDTH'(NAME_BUF_LEN))
                lv_name[rlen_reg[BW-1:0]] = ch;
            else
                lv_ntl = 1'b1;
            lv_len = rlen_reg + 1'b1;
        end
        else if (has_char && is_alpha)
        begin
            lv_name[0] = ch;
            lv_len = POS_WIDTH'(1);
            lv_ntl = 1'b0;
        end
    end

    // keyword match against the run
    always_comb
    begin
        logic eq;
        func_hit = 1'b0; func_idx = '0;
        const_hit = 1'b0; const_idx = '0;
        for (int i = N_FUNC - 1; i >= 0; i--)
        begin
            eq = !lv_ntl && (lv_len == POS_WIDTH'(func_len(i)));
            for (int j = 0; j < KW_CHARS; j++)
                if (j < NAME_BUF_LEN && j < int'(func_len(i)))
                    eq = eq && (lv_name[j] == func_text(i)[j*8 +: 8]);
            if (eq)
            begin
                func_hit = 1'b1;
                func_idx = 5'(i);
            end
        end
        for (int i = N_CONST - 1; i >= 0; i--)
        begin
            eq = !lv_ntl && (lv_len == POS_WIDTH'(const_len(i)));
            for (int j = 0; j < 2; j++)
                if (j < int'(const_len(i)))
                    eq = eq && (lv_name[j] == const_text(i)[j*8 +: 8]);
            if (eq)
            begin
                const_hit = 1'b1;
                const_idx = 5'(i);
            end
        end
    end

    always_comb
    begin
        logic [1:0] n;
        logic used;
        mode_t m;
        n = '0;
        used = 1'b0;
        m = mode_reg;
        mode_next = mode_reg; seen_next = seen_reg; ewp_next = ewp_reg;
        start_next = start_reg; rlen_next = rlen_reg; pos_next = pos_reg;
        ntl_next = ntl_reg;
        nw_en = 1'b0; nw_addr = '0;
        tok_ctl = '0; tok_start = '0; tok_len = '0; tok_kw = '0;

        if (has_char && m != MODE_DISCARD)
        begin
            if (pos_reg == POS_MAX)
            begin
                tok_ctl[n].kind = TK_ERROR; tok_ctl[n].chr = ch;
                tok_ctl[n].err = ERR_TOO_LONG; tok_start[n] = pos_reg;
                n = n + 2'd1; m = MODE_DISCARD; used = 1'b1;
            end
            if (!used && m == MODE_NUM)
            begin
                if (is_digit)
                begin
                    rlen_next = rlen_reg + 1'b1; ewp_next = 1'b0; used = 1'b1;
                end
                else if (ch == CH_POINT)
                begin
                    if (seen_reg)
                    begin
                        tok_ctl[n].kind = TK_ERROR; tok_ctl[n].chr = CH_POINT;
                        tok_ctl[n].err = ERR_SECOND_POINT; tok_start[n] = pos_reg;
                        n = n + 2'd1; m = MODE_DISCARD;
                    end
                    else
                    begin
                        seen_next = 1'b1; ewp_next = 1'b1; rlen_next = rlen_reg + 1'b1;
                    end
                    used = 1'b1;
                end
                else if (ewp_reg)
                begin
                    tok_ctl[n].kind = TK_ERROR; tok_ctl[n].chr = CH_POINT;
                    tok_ctl[n].err = ERR_TRAILING_POINT;
                    tok_start[n] = start_reg + rlen_reg - 1'b1;
                    n = n + 2'd1; m = MODE_DISCARD; used = 1'b1;
                end
                else
                begin
                    tok_ctl[n].kind = TK_NUMBER; tok_start[n] = start_reg;
                    tok_len[n] = rlen_reg; n = n + 2'd1; m = MODE_IDLE;
                end
            end
            if (!used && m == MODE_NAME)
            begin
                if (is_alpha)
                begin
                    if (rlen_reg < POS_WIDTH'(NAME_BUF_LEN))
                    begin
                        nw_en = 1'b1; nw_addr = rlen_reg[BW-1:0];
                    end
                    else
                        ntl_next = 1'b1;
                    rlen_next = rlen_reg + 1'b1; used = 1'b1;
                end
                else
                begin
                    tok_start[n] = start_reg; tok_len[n] = rlen_reg;
                    if (func_hit)
                    begin
                        tok_ctl[n].kind = TK_FUNC; tok_kw[n] = func_idx;
                    end
                    else if (const_hit)
                    begin
                        tok_ctl[n].kind = TK_CONST; tok_kw[n] = const_idx;
                    end
                    else
                        tok_ctl[n].kind = TK_IDENT;
                    n = n + 2'd1; m = MODE_IDLE;
                end
            end
            if (!used && m == MODE_IDLE)
            begin
                tok_start[n] = pos_reg; tok_len[n] = POS_WIDTH'(1); tok_ctl[n].chr = ch;
                if (is_ws)
                begin
                end
                else if (is_digit || ch == CH_POINT)
                begin
                    m = MODE_NUM; start_next = pos_reg; rlen_next = POS_WIDTH'(1);
                    seen_next = (ch == CH_POINT); ewp_next = (ch == CH_POINT);
                end
                else if (ch == 8'h2B || ch == 8'h2D)
                begin
                    tok_ctl[n].kind = TK_OPER; tok_ctl[n].prec = 2'd1; n = n + 2'd1;
                end
                else if (ch == 8'h2A || ch == 8'h2F || ch == CH_CARET)
                begin
                    tok_ctl[n].kind = TK_OPER; tok_ctl[n].prec = 2'd2; n = n + 2'd1;
                end
                else if (ch == 8'h28 || ch == 8'h29)
                begin
                    tok_ctl[n].kind = TK_PAREN; n = n + 2'd1;
                end
                else if (ch == 8'h2C)
                begin
                    tok_ctl[n].kind = TK_COMMA; n = n + 2'd1;
                end
                else if (ch == CH_EQ)
                begin
                    tok_ctl[n].kind = TK_EQUALS; n = n + 2'd1;
                end
                else if (is_alpha)
                begin
                    m = MODE_NAME; start_next = pos_reg; rlen_next = POS_WIDTH'(1);
                    nw_en = 1'b1; nw_addr = '0; ntl_next = 1'b0;
                end
                else
                begin
                    tok_ctl[n].kind = TK_ERROR; tok_ctl[n].err = ERR_UNEXPECTED;
                    tok_len[n] = '0; n = n + 2'd1; m = MODE_DISCARD;
                end
            end
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;
        end
        mode_next = m;

        if (last)
        begin
            // close a run still pending after this word's character;
            // the slot may hold leftovers of a skipped character
            if (m == MODE_NUM || m == MODE_NAME)
            begin
                tok_ctl[n] = '0; tok_kw[n] = '0;
                tok_start[n] = start_next; tok_len[n] = rlen_next;
                if (m == MODE_NUM)
                begin
                    if (ewp_next)
                    begin
                        tok_ctl[n].kind = TK_ERROR; tok_ctl[n].chr = CH_POINT;
                        tok_ctl[n].err = ERR_TRAILING_POINT;
                        tok_start[n] = start_next + rlen_next - 1'b1; tok_len[n] = '0;
                        m = MODE_DISCARD;
                    end
                    else
                        tok_ctl[n].kind = TK_NUMBER;
                end
                else if (func_hit)
                begin
                    tok_ctl[n].kind = TK_FUNC; tok_kw[n] = func_idx;
                end
                else if (const_hit)
                begin
                    tok_ctl[n].kind = TK_CONST; tok_kw[n] = const_idx;
                end
                else
                    tok_ctl[n].kind = TK_IDENT;
                n = n + 2'd1;
            end
            if (m != MODE_DISCARD)
            begin
                tok_ctl[n] = '0; tok_kw[n] = '0; tok_len[n] = '0;
                tok_ctl[n].kind = TK_END; tok_start[n] = pos_next; n = n + 2'd1;
            end
            mode_next = MODE_IDLE; seen_next = 1'b0; ewp_next = 1'b0;
            start_next = '0; rlen_next = '0; pos_next = '0; ntl_next = 1'b0;
        end
        if (n != 2'd0)
            tok_ctl[n - 2'd1].run_end = 1'b1;
        tok_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE; seen_reg <= 1'b0; ewp_reg <= 1'b0;
            start_reg <= '0; rlen_reg <= '0; pos_reg <= '0; ntl_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg <= mode_next; seen_reg <= seen_next; ewp_reg <= ewp_next;
            start_reg <= start_next; rlen_reg <= rlen_next; pos_reg <= pos_next;
            ntl_reg <= ntl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && nw_en)
            name_reg[nw_addr] <= ch;
    end
endmodule
`default_nettype wire

// ===== sv/exl_queue.sv =====
// Token queue between the lexer core and the output port.
`default_nettype none
module exl_queue
    import exl_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [1:0]           push_cnt,
    input  wire tok_ctl_t [MAX_TOK-1:0] push_ctl,
    input  wire logic [MAX_TOK-1:0][POS_WIDTH-1:0] push_start,
    input  wire logic [MAX_TOK-1:0][POS_WIDTH-1:0] push_len,
    input  wire logic [MAX_TOK-1:0][4:0] push_kw,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output tok_ctl_t                  out_ctl,
    output logic [POS_WIDTH-1:0]      out_start,
    output logic [POS_WIDTH-1:0]      out_len,
    output logic [4:0]                out_kw
);
    localparam int DEPTH = 8;
    localparam int AW = 3;

    tok_ctl_t             ctl_mem   [DEPTH];
    logic [POS_WIDTH-1:0] start_mem [DEPTH];
    logic [POS_WIDTH-1:0] len_mem   [DEPTH];
    logic [4:0]           kw_mem    [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pop;
    logic [1:0]    wn;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign room      = cnt_reg <= (AW+1)'(DEPTH - MAX_TOK);
    assign wn        = push ? push_cnt : 2'd0;
    assign cnt_next  = cnt_reg + (AW+1)'(wn) - (AW+1)'(pop);
    assign out_ctl   = ctl_mem[rp_reg];
    assign out_start = start_mem[rp_reg];
    assign out_len   = len_mem[rp_reg];
    assign out_kw    = kw_mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + AW'(wn);
            rp_reg  <= rp_reg + AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TOK; i++)
            if (2'(i) < wn)
            begin
                ctl_mem[wp_reg + AW'(i)]   <= push_ctl[i];
                start_mem[wp_reg + AW'(i)] <= push_start[i];
                len_mem[wp_reg + AW'(i)]   <= push_len[i];
                kw_mem[wp_reg + AW'(i)]    <= push_kw[i];
            end
    end
endmodule
`default_nettype wire

// ===== sv/expression_lexer.sv =====
// Top level of the expression lexer: front end, token queue, ports.
// Usage:
//   Input channel: one character word per cycle (ch, has_char, last) on
//   valid/ready. has_char = 0 with last = 1 closes an expression without
//   a character.
//   Output channel: one token word per cycle on valid/ready; run_end marks
//   the last token caused by an input word.
//   Each character word makes zero to three tokens, all computed in the
//   accept cycle and written at once into an eight-entry token queue.
//   Tokens are written into the queue when their character is taken.
//   Throughput: one character per cycle while the queue has room for
//   three more tokens; the output side drains one token per cycle
//   while out_ready is high; bursts of tokens are absorbed by the queue.
//   Receiver stall: the queue fills and ready drops when fewer than three
//   entries are free; no token is lost.
//   Reset: asynchronous, active low; clears lexer state and the queue.
//   Name storage holds no reset; only entries written in the current
//   letter run are compared.
`default_nettype none
`include "expression_lexer_defines.svh"
module expression_lexer
    import exl_pkg::*;
#(
    parameter int NAME_BUF_LEN = NAME_BUF_LEN_DEF,
    parameter int POS_WIDTH    = POS_WIDTH_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           ch,
    input  wire logic                 has_char,
    input  wire logic                 last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [3:0]                token_kind,
    output logic [1:0]                precedence,
    output logic [POS_WIDTH-1:0]      start_pos,
    output logic [POS_WIDTH-1:0]      token_len,
    output logic [7:0]                token_char,
    output logic [4:0]                keyword_index,
    output logic [1:0]                error_code,
    output logic                      run_end
);
    logic                 in_fire;
    logic [1:0]           tok_cnt;
    tok_ctl_t [MAX_TOK-1:0] tok_ctl;
    logic [MAX_TOK-1:0][POS_WIDTH-1:0] tok_start, tok_len;
    logic [MAX_TOK-1:0][4:0] tok_kw;
    tok_ctl_t             q_ctl;

    assign in_fire = in_valid && in_ready;

    exl_front #(.NAME_BUF_LEN(NAME_BUF_LEN), .POS_WIDTH(POS_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .ch(ch), .has_char(has_char), .last(last),
        .tok_cnt(tok_cnt), .tok_ctl(tok_ctl), .tok_start(tok_start),
        .tok_len(tok_len), .tok_kw(tok_kw)
    );

    exl_queue #(.POS_WIDTH(POS_WIDTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(in_fire), .push_cnt(tok_cnt),
        .push_ctl(tok_ctl), .push_start(tok_start), .push_len(tok_len),
        .push_kw(tok_kw), .room(in_ready), .out_valid(out_valid),
        .out_ready(out_ready), .out_ctl(q_ctl), .out_start(start_pos),
        .out_len(token_len), .out_kw(keyword_index)
    );

    assign token_kind = q_ctl.kind;
    assign precedence = q_ctl.prec;
    assign token_char = q_ctl.chr;
    assign error_code = q_ctl.err;
    assign run_end    = q_ctl.run_end;

    `EXL_ASSERT(a_cnt_max, clk, rst_n, in_fire |-> (tok_cnt <= 2'd3), "too many tokens")
    `EXL_ASSERT(a_last_end, clk, rst_n, (in_fire && tok_cnt != 2'd0) |-> tok_ctl[tok_cnt - 2'd1].run_end, "run_end missing")
    `EXL_ASSERT(a_prec, clk, rst_n, (out_valid && token_kind != TK_OPER) |-> (precedence == 2'd0), "precedence on non-operator")
endmodule
`default_nettype wire

// ===== tb/sv/tb_expression_lexer.sv =====
// Testbench for expression_lexer: directed table, random expressions, token predictor.
`timescale 1ns / 100ps
module tb_expression_lexer
    import exl_pkg::*;
;

    localparam int NBUF      = NAME_BUF_LEN_DEF;
    localparam int POS_LAST  = (1 << POS_WIDTH_DEF) - 1;
    localparam int IDLE_LIM  = 3000;   // cycles without any accepted word or token
    localparam int HOLD_CYC  = 300;    // long receiver hold-off

    // one character word plus optional directed expectation
    typedef struct {
        logic [7:0] c;
        logic       has;
        logic       lst;
        logic       chk;      // directed row: check kind/error of last token
        kind_t      ekind;
        err_t       eerr;
    } char_word_t;

    // one token word as it should leave the block
    typedef struct {
        kind_t       kind;
        logic [1:0]  prec;
        logic [15:0] start;
        logic [15:0] len;
        logic [7:0]  chr;
        logic [4:0]  kw;
        err_t        err;
        logic        rend;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        has_char;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  token_kind;
    logic [1:0]  precedence;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [7:0]  token_char;
    logic [4:0]  keyword_index;
    logic [1:0]  error_code;
    logic        run_end;

    expression_lexer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .ch(ch), .has_char(has_char), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .precedence(precedence),
        .start_pos(start_pos), .token_len(token_len),
        .token_char(token_char), .keyword_index(keyword_index),
        .error_code(error_code), .run_end(run_end)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: own copy of the lexer state.
    // ---------------------------------------------------------------
    string fn_names[] = '{"sin", "cos", "tan", "asin", "arcsin", "acos", "arccos",
                          "atan", "arctan", "log", "ln", "log10", "log2", "exp",
                          "sqrt", "cbrt", "root", "pow", "fact", "factorial"};
    string cn_names[] = '{"pi", "e", "g", "Na", "k", "h", "q"};

    mode_t       lx_mode;
    logic        lx_seen_pt;
    logic        lx_ends_pt;
    int          lx_start;
    int          lx_len;
    int          lx_pos;
    logic [7:0]  lx_name [NBUF];
    logic        lx_long;

    token_t      token_q[$];      // tokens still owed by the block
    char_word_t  words_q[$];      // character words still to send
    char_word_t  cur_word;        // word now on the input port

    int  mismatches;
    logic failed;

    task automatic lex_clear();
        lx_mode    = MODE_IDLE;
        lx_seen_pt = 1'b0;
        lx_ends_pt = 1'b0;
        lx_start   = 0;
        lx_len     = 0;
        lx_pos     = 0;
        lx_long    = 1'b0;
    endtask

    task automatic push_tok(kind_t k, int p, int s, int l, int c, int kw, err_t e);
        token_t t;
        t.kind  = k;
        t.prec  = p[1:0];
        t.start = s[15:0];
        t.len   = l[15:0];
        t.chr   = c[7:0];
        t.kw    = kw[4:0];
        t.err   = e;
        t.rend  = 1'b0;
        token_q = {token_q, t};
    endtask

    function automatic int find_name(input string tab[], input int cnt);
        string s;
        if (lx_long || lx_len > NBUF)
            return -1;
        s = "";
        for (int i = 0; i < lx_len; i++)
            s = {s, string'(lx_name[i])};
        for (int i = 0; i < cnt; i++)
            if (tab[i] == s)
                return i;
        return -1;
    endfunction

    // close a pending number or letter run
    task automatic close_run();
        int k;
        if (lx_mode == MODE_NUM)
        begin
            if (lx_ends_pt)
            begin
                push_tok(TK_ERROR, 0, lx_start + lx_len - 1, 0, CH_POINT, 0,
                         ERR_TRAILING_POINT);
                lx_mode = MODE_DISCARD;
                return;
            end
            push_tok(TK_NUMBER, 0, lx_start, lx_len, 0, 0, ERR_SECOND_POINT);
        end
        else if (lx_mode == MODE_NAME)
        begin
            k = find_name(fn_names, 20);
            if (k >= 0)
                push_tok(TK_FUNC, 0, lx_start, lx_len, 0, k, ERR_SECOND_POINT);
            else
            begin
                k = find_name(cn_names, 7);
                if (k >= 0)
                    push_tok(TK_CONST, 0, lx_start, lx_len, 0, k, ERR_SECOND_POINT);
                else
                    push_tok(TK_IDENT, 0, lx_start, lx_len, 0, 0, ERR_SECOND_POINT);
            end
        end
        else
            return;
        lx_mode = MODE_IDLE;
    endtask

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // work out the tokens caused by one accepted character word
    task automatic lex_word(char_word_t w);
        int   n0;
        int   p;
        logic done;
        n0 = token_q.size();
        if (w.has && lx_mode != MODE_DISCARD)
        begin
            p = lx_pos;
            done = 1'b0;
            if (p >= POS_LAST)
            begin
                push_tok(TK_ERROR, 0, p, 0, w.c, 0, ERR_TOO_LONG);
                lx_mode = MODE_DISCARD;
                done = 1'b1;
            end
            if (!done && lx_mode == MODE_NUM)
            begin
                if (is_num(w.c))
                begin
                    lx_len++;
                    lx_ends_pt = 1'b0;
                    done = 1'b1;
                end
                else if (w.c == CH_POINT)
                begin
                    if (lx_seen_pt)
                    begin
                        push_tok(TK_ERROR, 0, p, 0, CH_POINT, 0, ERR_SECOND_POINT);
                        lx_mode = MODE_DISCARD;
                    end
                    else
                    begin
                        lx_seen_pt = 1'b1;
                        lx_ends_pt = 1'b1;
                        lx_len++;
                    end
                    done = 1'b1;
                end
                else
                begin
                    close_run();
                    if (lx_mode == MODE_DISCARD)
                        done = 1'b1;
                end
            end
            if (!done && lx_mode == MODE_NAME)
            begin
                if (is_letter(w.c))
                begin
                    if (lx_len < NBUF)
                        lx_name[lx_len] = w.c;
                    else
                        lx_long = 1'b1;
                    lx_len++;
                    done = 1'b1;
                end
                else
                    close_run();
            end
            if (!done && lx_mode == MODE_IDLE)
            begin
                if (w.c == " " || w.c == CH_TAB || w.c == 8'h0A || w.c == 8'h0D)
                begin
                    // whitespace: nothing
                end
                else if (is_num(w.c) || w.c == CH_POINT)
                begin
                    lx_mode    = MODE_NUM;
                    lx_start   = p;
                    lx_len     = 1;
                    lx_seen_pt = (w.c == CH_POINT);
                    lx_ends_pt = (w.c == CH_POINT);
                end
                else if (w.c == "+" || w.c == "-")
                    push_tok(TK_OPER, 1, p, 1, w.c, 0, ERR_SECOND_POINT);
                else if (w.c == "*" || w.c == "/" || w.c == CH_CARET)
                    push_tok(TK_OPER, 2, p, 1, w.c, 0, ERR_SECOND_POINT);
                else if (w.c == "(" || w.c == ")")
                    push_tok(TK_PAREN, 0, p, 1, w.c, 0, ERR_SECOND_POINT);
                else if (w.c == ",")
                    push_tok(TK_COMMA, 0, p, 1, w.c, 0, ERR_SECOND_POINT);
                else if (w.c == CH_EQ)
                    push_tok(TK_EQUALS, 0, p, 1, w.c, 0, ERR_SECOND_POINT);
                else if (is_letter(w.c))
                begin
                    lx_mode    = MODE_NAME;
                    lx_start   = p;
                    lx_len     = 1;
                    lx_name[0] = w.c;
                    lx_long    = 1'b0;
                end
                else
                begin
                    push_tok(TK_ERROR, 0, p, 0, w.c, 0, ERR_UNEXPECTED);
                    lx_mode = MODE_DISCARD;
                end
            end
            if (p < POS_LAST)
                lx_pos = p + 1;
        end
        if (w.lst)
        begin
            close_run();
            if (lx_mode != MODE_DISCARD)
                push_tok(TK_END, 0, lx_pos, 0, 0, 0, ERR_SECOND_POINT);
            lex_clear();
        end
        if (token_q.size() > n0)
            token_q[token_q.size() - 1].rend = 1'b1;
        // directed rows carry a hand-written expectation for their last token
        if (w.chk)
        begin
            if (token_q.size() == n0 || token_q[$].kind != w.ekind ||
                (w.ekind == TK_ERROR && token_q[$].err != w.eerr))
            begin
                failed = 1'b1;
                $display("directed row '%s': predicted token does not match table", w.c);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Monitors. Inputs only move at the rising edge, so the values at
    // the falling edge tell exactly which words the next edge accepts.
    // ---------------------------------------------------------------
    int idle_cnt;

    always @(negedge clk)
    begin
        token_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                lex_word(cur_word);
            if (out_valid && out_ready)
            begin
                if (token_q.size() == 0)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token: kind %0d start %0d",
                                 token_kind, start_pos);
                end
                else
                begin
                    e = token_q.pop_front();
                    if (token_kind !== e.kind || precedence !== e.prec ||
                        start_pos !== e.start || token_len !== e.len ||
                        token_char !== e.chr || keyword_index !== e.kw ||
                        error_code !== e.err || run_end !== e.rend)
                    begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("token mismatch: exp k%0d p%0d s%0d l%0d c%0h kw%0d e%0d r%0d",
                                     e.kind, e.prec, e.start, e.len, e.chr, e.kw, e.err,
                                     e.rend);
                            $display("                got k%0d p%0d s%0d l%0d c%0h kw%0d e%0d r%0d",
                                     token_kind, precedence, start_pos, token_len,
                                     token_char, keyword_index, error_code, run_end);
                        end
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIM)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall pattern, quiet stretches, one long hold-off.
    // ---------------------------------------------------------------
    logic hold_req;

    initial
    begin
        logic [15:0] pat;
        int          k;
        int          plen;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_req = 1'b0;
            end
            pat  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            plen = 16 * $urandom_range(1, 6);
            for (k = 0; k < plen; k++)
            begin
                @(posedge clk);
                if (hold_req)
                    break;
                out_ready <= pat[k % 16];
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    logic gapless;

    task automatic send_word(char_word_t w);
        logic ok;
        cur_word = w;
        in_valid <= 1'b1;
        ch       <= w.c;
        has_char <= w.has;
        last     <= w.lst;
        do
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end while (!ok);
    endtask

    // send the queued words in bursts with random gaps, or all at once when gapless
    task automatic drain_words();
        int burst;
        while (words_q.size() > 0)
        begin
            burst = gapless ? words_q.size() : $urandom_range(1, 24);
            while (burst > 0 && words_q.size() > 0)
            begin
                send_word(words_q.pop_front());
                burst--;
            end
            if (!gapless && $urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic add_word(logic [7:0] c, logic has, logic lst);
        char_word_t w;
        w.c = c; w.has = has; w.lst = lst;
        w.chk = 1'b0; w.ekind = TK_NUMBER; w.eerr = ERR_SECOND_POINT;
        words_q = {words_q, w};
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_word(s[i], 1'b1, 1'b0);
    endtask

    // one random expression, mostly well formed
    task automatic add_expression();
        int    ntok;
        int    sel;
        int    m;
        string ops;
        string ws;
        ops  = "+-*/^(),=";
        ws   = " \t\n\r";
        ntok = $urandom_range(1, 9);
        for (int t = 0; t < ntok; t++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 5)
            begin
                // number, sometimes with a misplaced point
                m = $urandom_range(1, 4);
                for (int i = 0; i < m; i++)
                    add_word(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
                if ($urandom_range(0, 2) == 0) add_word(CH_POINT, 1'b1, 1'b0);
                if ($urandom_range(0, 1) == 0)
                    add_word(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
                if ($urandom_range(0, 15) == 0) add_word(CH_POINT, 1'b1, 1'b0);
            end
            else if (sel < 8)
                add_text(fn_names[$urandom_range(0, 19)]);
            else if (sel < 10)
                add_text(cn_names[$urandom_range(0, 6)]);
            else if (sel < 12)
            begin
                m = $urandom_range(1, 12);
                for (int i = 0; i < m; i++)
                    add_word(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                                     : "A" + $urandom_range(0, 25)),
                             1'b1, 1'b0);
            end
            else if (sel < 17)
                add_word(ops[$urandom_range(0, 8)], 1'b1, 1'b0);
            else if (sel < 19)
                add_word(ws[$urandom_range(0, 3)], 1'b1, 1'b0);
            else
                add_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        // close on the final character or with an empty word
        if ($urandom_range(0, 2) == 0)
            add_word(8'($urandom), 1'b0, 1'b1);
        else
            words_q[$].lst = 1'b1;
    endtask

    // directed rows: ch, has_char, last, check, kind, error
    typedef struct {
        logic [7:0] c;
        logic       has;
        logic       lst;
        logic       chk;
        kind_t      ekind;
        err_t       eerr;
    } row_t;

    row_t dir_rows[23] = '{
        '{"N", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{"a", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{"=", 1, 0, 1, TK_EQUALS, ERR_SECOND_POINT},       // closes the constant
        '{".", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{"5", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{"^", 1, 0, 1, TK_OPER, ERR_SECOND_POINT},
        '{"x", 1, 1, 1, TK_END, ERR_SECOND_POINT},
        '{"(", 1, 0, 1, TK_PAREN, ERR_SECOND_POINT},
        '{"1", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{".", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{".", 1, 0, 1, TK_ERROR, ERR_SECOND_POINT},        // second point
        '{"+", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},       // discarded
        '{8'h00, 0, 1, 0, TK_NUMBER, ERR_SECOND_POINT},     // no end token
        '{"7", 1, 0, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{".", 1, 1, 1, TK_ERROR, ERR_TRAILING_POINT},
        '{"@", 1, 0, 1, TK_ERROR, ERR_UNEXPECTED},
        '{8'hFF, 1, 1, 0, TK_NUMBER, ERR_SECOND_POINT},
        '{8'h00, 0, 1, 1, TK_END, ERR_SECOND_POINT},        // empty expression
        '{"-", 1, 0, 1, TK_OPER, ERR_SECOND_POINT},
        '{")", 1, 0, 1, TK_PAREN, ERR_SECOND_POINT},
        '{"*", 1, 0, 1, TK_OPER, ERR_SECOND_POINT},
        '{",", 1, 0, 1, TK_COMMA, ERR_SECOND_POINT},
        '{8'h09, 1, 1, 1, TK_END, ERR_SECOND_POINT}
    };

    task automatic wait_drained();
        while (token_q.size() > 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        char_word_t w;
        in_valid   = 1'b0;
        ch         = '0;
        has_char   = 1'b0;
        last       = 1'b0;
        rst_n      = 1'b0;
        hold_req   = 1'b0;
        gapless    = 1'b0;
        mismatches = 0;
        failed     = 1'b0;
        idle_cnt   = 0;
        cur_word   = '{8'h00, 1'b0, 1'b0, 1'b0, TK_NUMBER, ERR_SECOND_POINT};
        lex_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            w.c = dir_rows[i].c; w.has = dir_rows[i].has; w.lst = dir_rows[i].lst;
            w.chk = dir_rows[i].chk; w.ekind = dir_rows[i].ekind; w.eerr = dir_rows[i].eerr;
            words_q = {words_q, w};
        end
        drain_words();
        // sender pauses until every token is out
        wait_drained();

        // receiver holds off while operators keep coming: queue fills
        hold_req = 1'b1;
        @(posedge clk);
        @(posedge clk);
        for (int i = 0; i < 40; i++)
            add_word("+", 1'b1, 1'b0);
        add_word(8'h00, 1'b0, 1'b1);
        gapless = 1'b1;
        drain_words();
        gapless = 1'b0;

        // random expressions, bringing the run to about 160 words
        while (words_q.size() < 96)
            add_expression();
        drain_words();

        wait_drained();
        repeat (20) @(posedge clk);
        if (!failed && mismatches == 0 && token_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
